### rtl/playlist_slot_navigator_assert.svh
// Assertion macros shared by the playlist slot navigator checkers.
`ifndef PLAYLIST_SLOT_NAVIGATOR_ASSERT_SVH
`define PLAYLIST_SLOT_NAVIGATOR_ASSERT_SVH

// Clocked check, masked while reset is high.
`define PSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define PSN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/psn_pkg.sv
// Shared types and constants of the playlist slot navigator.
package psn_pkg;

  localparam int REQ_W  = 4;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 32;
  localparam int ACT_W  = 3;
  localparam int VOL_W  = 6;
  localparam int TRK_W  = 8;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // output tdata layout, lowest bit first
  localparam int OUT_ACT_LSB  = 0;
  localparam int OUT_VOL_LSB  = 3;
  localparam int OUT_SLOT_LSB = 9;
  localparam int OUT_TRK_LSB  = 13;
  localparam int OUT_RES_LSB  = 21;
  localparam int OUT_FV_BIT   = 53;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOL   = 2'd2;

  localparam logic [REQ_W-1:0] REQ_VOL_UP   = 4'd0;
  localparam logic [REQ_W-1:0] REQ_VOL_DOWN = 4'd1;
  localparam logic [REQ_W-1:0] REQ_PLAY     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_PAUSE    = 4'd3;
  localparam logic [REQ_W-1:0] REQ_PREV     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_NEXT     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SELECT   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_END      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_SHUTDOWN = 4'd8;

  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_VOLUME = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_HALT   = 3'd4;

  localparam logic [VOL_W-1:0] VOL_RESET    = 6'd16;
  localparam logic [VOL_W-1:0] MAXVOL_RESET = 6'd63;
  localparam logic [TRK_W-1:0] TRK_RESET    = 8'hFF;

  typedef struct packed {
    logic load;     // latch the accepted request
    logic exec;     // apply the request to the player state
    logic step;     // move the cursor one slot around the ring
    logic capture;  // load the output register
  } psn_cmd_t;

  typedef struct packed {
    logic searching;  // ring search still running
    logic out_free;   // output register can take a result
  } psn_status_t;

endpackage

### rtl/psn_datapath.sv
// Datapath: player state, configuration, ring search stepper and output register.
module psn_datapath #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psn_pkg::psn_cmd_t                   cmd,
  output psn_pkg::psn_status_t                status,
  input  logic [psn_pkg::REQ_W-1:0]           in_req,
  input  logic [psn_pkg::SLOT_W-1:0]          in_sel,
  input  logic [psn_pkg::POS_W-1:0]           in_pos,
  input  logic                                cfg_we,
  input  logic [psn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [psn_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int STEP_W = $clog2(NUM_SLOTS + 1);
  localparam logic [psn_pkg::SLOT_W-1:0] LAST_SLOT = psn_pkg::SLOT_W'(NUM_SLOTS - 1);
  localparam logic [psn_pkg::SLOT_W:0]   SLOT_LIM  = (psn_pkg::SLOT_W + 1)'(NUM_SLOTS);
  localparam logic [STEP_W-1:0]          STEP_MAX  = STEP_W'(NUM_SLOTS);
  localparam logic [psn_pkg::TRK_W-1:0]  CNT_MASK  = psn_pkg::TRK_W'((1 << COUNT_BITS) - 1);

  // configuration
  logic [psn_pkg::CFG_DATA_W-1:0] counts_lo, counts_hi;
  logic [psn_pkg::VOL_W-1:0]      max_vol;

  // player state
  logic [psn_pkg::VOL_W-1:0]  vol, vol_next;
  logic [psn_pkg::SLOT_W-1:0] cur, cur_next;
  logic [psn_pkg::TRK_W-1:0]  trk, trk_next;
  logic [psn_pkg::POS_W-1:0]  paused, paused_next;
  logic                       running, running_next;

  // latched request
  logic [psn_pkg::REQ_W-1:0]  req_r;
  logic [psn_pkg::SLOT_W-1:0] sel_r;
  logic [psn_pkg::POS_W-1:0]  pos_r;

  // per-request bookkeeping
  logic [psn_pkg::ACT_W-1:0]  act_r, act_next;
  logic                       move_r, move_next;
  logic [psn_pkg::POS_W-1:0]  resume_r, resume_next;
  logic                       searching, searching_next;
  logic                       search_back, search_back_next;
  logic [STEP_W-1:0]          steps, steps_next;

  logic [psn_pkg::OUT_TDATA_W-1:0] out_data;

  function automatic logic [psn_pkg::TRK_W-1:0] count_of(
    input logic [psn_pkg::SLOT_W-1:0]       s,
    input logic [2*psn_pkg::CFG_DATA_W-1:0] all
  );
    logic [psn_pkg::TRK_W-1:0] b;
    b = all[{s, 3'b000} +: psn_pkg::TRK_W];
    if ({1'b0, s} >= SLOT_LIM) begin
      return '0;
    end
    return b & CNT_MASK;
  endfunction

  function automatic logic [psn_pkg::SLOT_W-1:0] slot_after(
    input logic [psn_pkg::SLOT_W-1:0] s
  );
    return (s >= LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [psn_pkg::SLOT_W-1:0] slot_before(
    input logic [psn_pkg::SLOT_W-1:0] s
  );
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  logic [2*psn_pkg::CFG_DATA_W-1:0] counts_all;
  logic [psn_pkg::TRK_W-1:0]        cnt_cur, cnt_sel, cnt_step, trk_inc;
  logic [psn_pkg::SLOT_W-1:0]       cur_step;
  logic                             cur_valid, sel_ok;
  logic [STEP_W-1:0]                steps_inc;
  logic                             step_stop;

  assign counts_all = {counts_hi, counts_lo};
  assign cnt_cur    = count_of(cur, counts_all);
  assign cnt_sel    = count_of(sel_r, counts_all);
  assign trk_inc    = trk + 1'b1;
  assign cur_valid  = trk < cnt_cur;
  assign sel_ok     = {1'b0, sel_r} < SLOT_LIM;

  // one ring step
  assign cur_step  = search_back ? slot_before(cur) : slot_after(cur);
  assign cnt_step  = count_of(cur_step, counts_all);
  assign steps_inc = steps + 1'b1;
  assign step_stop = (cnt_step != '0) || (steps_inc == STEP_MAX);

  always_comb begin
    vol_next         = vol;
    cur_next         = cur;
    trk_next         = trk;
    paused_next      = paused;
    running_next     = running;
    act_next         = act_r;
    move_next        = move_r;
    resume_next      = resume_r;
    searching_next   = searching;
    search_back_next = search_back;
    steps_next       = steps;

    if (cmd.exec) begin
      act_next         = psn_pkg::ACT_NONE;
      move_next        = 1'b0;
      resume_next      = '0;
      searching_next   = 1'b0;
      search_back_next = 1'b0;
      steps_next       = '0;
      if (running) begin
        case (req_r)
          psn_pkg::REQ_VOL_UP: begin
            if (vol < max_vol) begin
              vol_next = vol + 1'b1;
              act_next = psn_pkg::ACT_VOLUME;
            end
          end
          psn_pkg::REQ_VOL_DOWN: begin
            if (vol != '0) begin
              vol_next = vol - 1'b1;
              act_next = psn_pkg::ACT_VOLUME;
            end
          end
          psn_pkg::REQ_PLAY: begin
            if (cur_valid) begin
              act_next    = psn_pkg::ACT_START;
              resume_next = paused;
            end
          end
          psn_pkg::REQ_PAUSE: begin
            paused_next = pos_r;
            act_next    = psn_pkg::ACT_STOP;
          end
          psn_pkg::REQ_PREV: begin
            move_next = 1'b1;
            if (trk != '0) begin
              trk_next = trk - 1'b1;
            end else begin
              searching_next   = 1'b1;
              search_back_next = 1'b1;
            end
          end
          psn_pkg::REQ_NEXT, psn_pkg::REQ_END: begin
            move_next = 1'b1;
            if (cnt_cur <= trk_inc) begin
              trk_next       = '0;
              searching_next = 1'b1;
            end else begin
              trk_next = trk_inc;
            end
          end
          psn_pkg::REQ_SELECT: begin
            if (sel_ok) begin
              move_next = 1'b1;
              if (cur == sel_r) begin
                trk_next = (cnt_cur <= trk_inc) ? '0 : trk_inc;
              end else begin
                cur_next       = sel_r;
                trk_next       = '0;
                searching_next = (cnt_sel == '0);
              end
            end
          end
          psn_pkg::REQ_SHUTDOWN: begin
            running_next = 1'b0;
            act_next     = psn_pkg::ACT_HALT;
          end
          default: ;
        endcase
      end
    end else if (cmd.step) begin
      cur_next   = cur_step;
      steps_next = steps_inc;
      if (step_stop) begin
        searching_next = 1'b0;
        // stepping back lands on the last track of the new slot
        if (search_back) begin
          trk_next = cnt_step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_lo <= '0;
      counts_hi <= '0;
      max_vol   <= psn_pkg::MAXVOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psn_pkg::CFG_COUNTS_LO: counts_lo <= cfg_data;
        psn_pkg::CFG_COUNTS_HI: counts_hi <= cfg_data;
        psn_pkg::CFG_MAX_VOL:   max_vol   <= cfg_data[psn_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vol       <= psn_pkg::VOL_RESET;
      cur       <= '0;
      trk       <= psn_pkg::TRK_RESET;
      paused    <= '0;
      running   <= 1'b1;
      searching <= 1'b0;
      move_r    <= 1'b0;
      act_r     <= psn_pkg::ACT_NONE;
    end else begin
      vol       <= vol_next;
      cur       <= cur_next;
      trk       <= trk_next;
      paused    <= paused_next;
      running   <= running_next;
      searching <= searching_next;
      move_r    <= move_next;
      act_r     <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    search_back <= search_back_next;
    steps       <= steps_next;
    resume_r    <= resume_next;
    if (cmd.load) begin
      req_r <= in_req;
      sel_r <= in_sel;
      pos_r <= in_pos;
    end
  end

  // output register
  logic [psn_pkg::ACT_W-1:0] act_out;
  assign act_out = move_r ? (cur_valid ? psn_pkg::ACT_START : psn_pkg::ACT_NONE) : act_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_data <= {2'b00, cur_valid, resume_r, trk, cur, vol, act_out};
    end
  end

  assign m_tdata          = out_data;
  assign status.searching = searching;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

### rtl/psn_ctrl.sv
// Controller: sequences accept, execute, ring search and result capture.
module psn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  psn_pkg::psn_status_t status,
  output psn_pkg::psn_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.searching) begin
          cmd.step = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/playlist_slot_navigator.sv
// Top level of the playlist slot navigator: media-player request controller.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request kind, s_tdata
//   the selected slot and the current sample position. Each request gives
//   exactly one result on the m_ stream: action, volume, cursor slot and track,
//   resume offset and a file-valid flag.
//   Slot track counts and the volume ceiling are written through the cfg port
//   (index 0: slots 0-7, index 1: slots 8-15, index 2: max volume); cfg_ready
//   is always high. Write config only while no request is in flight.
// Timing:
//   A request is latched, executed in the next cycle, then the cursor steps one
//   slot per cycle around the ring while it looks for a non-empty slot (zero to
//   NUM_SLOTS steps), and the result is loaded into the output register.
//   A new request waits until the last result is in the output register.
//   The ring stepper is the only multi-cycle part.
// Reset:
//   Synchronous rst restores volume 16, slot 0, track 255, pause offset 0,
//   running, all counts zero, max volume 63, and drops m_tvalid.
// Stalls:
//   A finished result waits in the output register; one more request can be
//   accepted and executed behind it, and then the controller holds in its
//   final state until m_tready frees the register.
module playlist_slot_navigator #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [psn_pkg::IN_TDATA_W-1:0]      s_tdata,   // slot_index, sample_position, zero pad
  input  logic [psn_pkg::REQ_W-1:0]           s_tuser,   // req_type
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [psn_pkg::OUT_TDATA_W-1:0]     m_tdata,   // action, volume, slot,
                                                         // position_in_slot, resume_position,
                                                         // file_valid, zero pad
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psn_pkg::CFG_DATA_W-1:0]      cfg_data
);

  psn_pkg::psn_cmd_t    cmd;
  psn_pkg::psn_status_t status;

  // config is always accepted
  assign cfg_ready = 1'b1;

  psn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psn_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_req    (s_tuser),
    .in_sel    (s_tdata[psn_pkg::SLOT_W-1:0]),
    .in_pos    (s_tdata[psn_pkg::SLOT_W +: psn_pkg::POS_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

### rtl/psn_checker.sv
// Port-level checker for the playlist slot navigator, bound to the top level.
`include "playlist_slot_navigator_assert.svh"

module psn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [psn_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [psn_pkg::ACT_W-1:0] act;
  assign act = m_tdata[psn_pkg::OUT_ACT_LSB +: psn_pkg::ACT_W];

  `PSN_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `PSN_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")
  `PSN_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second request taken while one is executing")
  `PSN_ASSERT(a_start_needs_file, m_tvalid && act == psn_pkg::ACT_START |-> m_tdata[psn_pkg::OUT_FV_BIT], "start playing without a valid file")

endmodule

bind playlist_slot_navigator psn_checker u_psn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
